[src/tdpc_pkg.sv]
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared types and constants for the two-dimensional parity checker.
// ----------------------------------------------------------------------------
package tdpc_pkg;

	localparam int MaxSize   = 64;
	localparam int IdxW      = $clog2(MaxSize);
	localparam int SizeW     = 7;
	localparam int CountW    = 2;
	localparam int ResetSize = 4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CORRUPT = 2'd1,
		ST_CHANGE  = 2'd2
	} status_t;

	// control from the sequencer to the column parity ring
	typedef struct packed {
		logic shift;
		logic clear;
	} ring_ctl_t;

endpackage

[src/tdpc_cell.sv]
// ----------------------------------------------------------------------------
// tdpc_cell
// One column parity bit of the ring; takes its neighbour's bit on each shift.
// ----------------------------------------------------------------------------
module tdpc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tdpc_pkg::ring_ctl_t ctl,
	input  logic              d,
	output logic              q
);

	logic par_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= 1'b0;
		end else if (ctl.clear) begin
			par_q <= 1'b0;
		end else if (ctl.shift) begin
			par_q <= d;
		end
	end

	assign q = par_q;

endmodule

[src/tdpc_ring.sv]
// ----------------------------------------------------------------------------
// tdpc_ring
// Chain of column parity cells closed into a ring of the configured length.
// ----------------------------------------------------------------------------
module tdpc_ring (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tdpc_pkg::ring_ctl_t        ctl,
	input  logic                       bit_in,
	input  logic [tdpc_pkg::IdxW-1:0]  tap_sel,
	output logic                       tap
);

	logic [tdpc_pkg::MaxSize-1:0] cell_q;
	logic                         head_d;

	// the tap cell always holds the parity of the column now arriving
	assign tap    = cell_q[tap_sel];
	assign head_d = tap ^ bit_in;

	for (genvar i = 0; i < tdpc_pkg::MaxSize; i++) begin : g_cell
		if (i == 0) begin : g_head
			tdpc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (head_d),
				.q      (cell_q[i])
			);
		end else begin : g_body
			tdpc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (cell_q[i-1]),
				.q      (cell_q[i])
			);
		end
	end

endmodule

[src/two_dim_parity_checker.sv]
// A result is presented in the cycle after the last bit of a matrix is taken.
// One bit per cycle unless stalled; the column ring and counters update per bit.
// The input stalls only when a result is due while the previous one still waits.
// Reset: matrix size 4, all parities, counters and positions cleared, no result held.
// A size write clears parities, counters and positions and starts a new matrix.
// ----------------------------------------------------------------------------
// two_dim_parity_checker
// Streams a square bit matrix and reports OK, a correctable bit or corrupt.
// ----------------------------------------------------------------------------
module two_dim_parity_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       size_valid,
	output logic       size_ready,
	input  logic [6:0] matrix_size,
	input  logic       bit_valid,
	output logic       bit_stall,
	input  logic       bit_value,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] status,
	output logic [6:0] error_row,
	output logic [6:0] error_column
);

	localparam logic [tdpc_pkg::IdxW-1:0] ResetM1 = tdpc_pkg::IdxW'(tdpc_pkg::ResetSize - 1);
	localparam logic [tdpc_pkg::SizeW-1:0] MaxSz = tdpc_pkg::SizeW'(tdpc_pkg::MaxSize);
	localparam logic [tdpc_pkg::CountW-1:0] CntSat = tdpc_pkg::CountW'(2);

	logic [tdpc_pkg::IdxW-1:0]   size_m1_q;
	logic [tdpc_pkg::IdxW-1:0]   col_pos_q, row_pos_q;
	logic                        row_par_q;
	logic [tdpc_pkg::CountW-1:0] rows_q, cols_q, rows_n, cols_n;
	logic [tdpc_pkg::IdxW-1:0]   frow_q, fcol_q, frow_n, fcol_n;
	logic                        result_valid_q;
	tdpc_pkg::status_t           status_q, status_n;
	logic [tdpc_pkg::SizeW-1:0]  error_row_q, error_column_q;
	logic [tdpc_pkg::SizeW-1:0]  er_n, ec_n;
	logic [tdpc_pkg::IdxW-1:0]   size_m1_d;

	logic                cfg_we, accept, last_col, last_row, last, out_free;
	logic                row_par_new, col_new, tap;
	tdpc_pkg::ring_ctl_t ring_ctl;

	assign size_ready = 1'b1;
	assign cfg_we     = size_valid & size_ready;

	assign last_col = (col_pos_q == size_m1_q);
	assign last_row = (row_pos_q == size_m1_q);
	assign last     = last_col & last_row;
	assign out_free = ~result_valid_q | ~result_stall;
	assign bit_stall = last & ~out_free;
	assign accept   = bit_valid & ~bit_stall;

	assign ring_ctl.shift = accept;
	assign ring_ctl.clear = cfg_we | (accept & last);

	tdpc_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.bit_in  (bit_value),
		.tap_sel (size_m1_q),
		.tap     (tap)
	);

	assign row_par_new = row_par_q ^ bit_value;
	assign col_new     = tap ^ bit_value;

	// zero acts as one, anything above the ring length as the ring length
	always_comb begin
		if (matrix_size == '0) begin
			size_m1_d = '0;
		end else if (matrix_size > MaxSz) begin
			size_m1_d = tdpc_pkg::IdxW'(tdpc_pkg::MaxSize - 1);
		end else begin
			size_m1_d = tdpc_pkg::IdxW'(matrix_size - 7'd1);
		end
	end

	// odd row and odd column tallies including the current item
	always_comb begin
		rows_n = rows_q;
		frow_n = frow_q;
		cols_n = cols_q;
		fcol_n = fcol_q;
		if (last_col && row_par_new) begin
			if (rows_q == '0) begin
				frow_n = row_pos_q;
			end
			if (rows_q != CntSat) begin
				rows_n = rows_q + 2'd1;
			end
		end
		// columns are final as they pass during the last row
		if (last_row && col_new) begin
			if (cols_q == '0) begin
				fcol_n = col_pos_q;
			end
			if (cols_q != CntSat) begin
				cols_n = cols_q + 2'd1;
			end
		end
		er_n = '0;
		ec_n = '0;
		if (rows_n == '0 && cols_n == '0) begin
			status_n = tdpc_pkg::ST_OK;
		end else if (rows_n == 2'd1 && cols_n == 2'd1) begin
			status_n = tdpc_pkg::ST_CHANGE;
			er_n     = {1'b0, frow_n} + 7'd1;
			ec_n     = {1'b0, fcol_n} + 7'd1;
		end else begin
			status_n = tdpc_pkg::ST_CORRUPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_m1_q <= ResetM1;
			col_pos_q <= '0;
			row_pos_q <= '0;
			row_par_q <= 1'b0;
			rows_q    <= '0;
			cols_q    <= '0;
			frow_q    <= '0;
			fcol_q    <= '0;
		end else if (cfg_we) begin
			size_m1_q <= size_m1_d;
			col_pos_q <= '0;
			row_pos_q <= '0;
			row_par_q <= 1'b0;
			rows_q    <= '0;
			cols_q    <= '0;
			frow_q    <= '0;
			fcol_q    <= '0;
		end else if (accept) begin
			if (last) begin
				col_pos_q <= '0;
				row_pos_q <= '0;
				row_par_q <= 1'b0;
				rows_q    <= '0;
				cols_q    <= '0;
				frow_q    <= '0;
				fcol_q    <= '0;
			end else begin
				rows_q <= rows_n;
				cols_q <= cols_n;
				frow_q <= frow_n;
				fcol_q <= fcol_n;
				if (last_col) begin
					col_pos_q <= '0;
					row_pos_q <= row_pos_q + 1'b1;
					row_par_q <= 1'b0;
				end else begin
					col_pos_q <= col_pos_q + 1'b1;
					row_par_q <= row_par_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			status_q       <= status_n;
			error_row_q    <= er_n;
			error_column_q <= ec_n;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign error_row    = error_row_q;
	assign error_column = error_column_q;

	// assertions
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_pos_q <= size_m1_q && row_pos_q <= size_m1_q)
		else $error("position beyond matrix size");

	a_change_located: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && status_q == tdpc_pkg::ST_CHANGE |->
			error_row_q != '0 && error_column_q != '0)
		else $error("correctable item without location");

	a_no_location: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && status_q != tdpc_pkg::ST_CHANGE |->
			error_row_q == '0 && error_column_q == '0)
		else $error("location given without correctable bit");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> result_valid_q && col_pos_q == '0 && row_pos_q == '0)
		else $error("matrix end not reported");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams square bit matrices into the two-dimensional parity checker and
// compares every report against a parity predictor kept alongside it, under
// random gaps on the bit input and random stalls on the report output.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		tdpc_pkg::status_t          st;
		logic [tdpc_pkg::SizeW-1:0] row;
		logic [tdpc_pkg::SizeW-1:0] col;
	} parity_report_t;

	logic                       clk;
	logic                       arst_n;
	logic                       size_valid;
	logic                       size_ready;
	logic [tdpc_pkg::SizeW-1:0] matrix_size;
	logic                       bit_valid;
	logic                       bit_stall;
	logic                       bit_value;
	logic                       result_valid;
	logic                       result_stall;
	logic [1:0]                 status;
	logic [tdpc_pkg::SizeW-1:0] error_row;
	logic [tdpc_pkg::SizeW-1:0] error_column;

	two_dim_parity_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.size_valid   (size_valid),
		.size_ready   (size_ready),
		.matrix_size  (matrix_size),
		.bit_valid    (bit_valid),
		.bit_stall    (bit_stall),
		.bit_value    (bit_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.error_row    (error_row),
		.error_column (error_column)
	);

	// predictor state
	logic [tdpc_pkg::SizeW-1:0] cur_size;
	logic                       col_par [tdpc_pkg::MaxSize];
	logic                       row_par;
	int                         row_pos;
	int                         col_pos;
	int                         odd_rows;
	int                         first_odd;

	parity_report_t   expected_reports[$];

	int  errors;
	int  items_sent;
	int  n_ok;
	int  n_corrupt;
	int  n_change;
	bit  calm;
	bit  hold_req;
	int  hold_left;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Timeout: %0d reports still outstanding", expected_reports.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 50)
			$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic int active_size();
		if (cur_size == 0)
			return 1;
		if (cur_size > tdpc_pkg::MaxSize)
			return tdpc_pkg::MaxSize;
		return cur_size;
	endfunction

	task automatic clear_parity();
		for (int c = 0; c < tdpc_pkg::MaxSize; c++)
			col_par[c] = 1'b0;
		row_par   = 1'b0;
		row_pos   = 0;
		col_pos   = 0;
		odd_rows  = 0;
		first_odd = 0;
	endtask

	task automatic predict_bit(input logic b);
		int n;
		int odd_cols;
		int first_col;
		parity_report_t r;
		n = active_size();
		if (col_pos >= n)
			col_pos = 0;
		if (row_pos >= n)
			row_pos = 0;
		row_par          = row_par ^ b;
		col_par[col_pos] = col_par[col_pos] ^ b;
		col_pos++;
		if (col_pos < n)
			return;
		if (row_par) begin
			if (odd_rows == 0)
				first_odd = row_pos;
			if (odd_rows < 2)
				odd_rows++;
		end
		row_par = 1'b0;
		col_pos = 0;
		row_pos++;
		if (row_pos < n)
			return;
		odd_cols  = 0;
		first_col = 0;
		for (int c = 0; c < n; c++) begin
			if (col_par[c]) begin
				if (odd_cols == 0)
					first_col = c;
				if (odd_cols < 2)
					odd_cols++;
			end
		end
		r.row = '0;
		r.col = '0;
		if (odd_rows == 0 && odd_cols == 0) begin
			r.st = tdpc_pkg::ST_OK;
		end else if (odd_rows == 1 && odd_cols == 1) begin
			r.st  = tdpc_pkg::ST_CHANGE;
			r.row = tdpc_pkg::SizeW'(first_odd + 1);
			r.col = tdpc_pkg::SizeW'(first_col + 1);
		end else begin
			r.st = tdpc_pkg::ST_CORRUPT;
		end
		expected_reports.push_back(r);
		clear_parity();
	endtask

	task automatic send_bit(input logic b);
		while (!calm && $urandom_range(0, 99) < 31) begin
			bit_valid <= 1'b0;
			bit_value <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		bit_valid <= 1'b1;
		bit_value <= b;
		do @(posedge clk); while (bit_stall);
		predict_bit(b);
		items_sent++;
	endtask

	// wait for every report, then let a matrix still in flight settle
	task automatic drain();
		bit_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input logic [tdpc_pkg::SizeW-1:0] v);
		drain();
		size_valid  <= 1'b1;
		matrix_size <= v;
		do @(posedge clk); while (!size_ready);
		size_valid <= 1'b0;
		cur_size = v;
		clear_parity();
	endtask

	// flips < 0 gives a noise matrix; otherwise a matrix with even parity
	// everywhere and then flips bits toggled, the first at (fr, fc) if given
	task automatic send_matrix(input int n, input int flips, input int fr, input int fc);
		logic grid [tdpc_pkg::MaxSize][tdpc_pkg::MaxSize];
		int r;
		int c;
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				grid[r][c] = (flips < 0 || (r < n - 1 && c < n - 1)) ?
					1'($urandom_range(0, 1)) : 1'b0;
		if (flips >= 0) begin
			for (r = 0; r < n - 1; r++)
				for (c = 0; c < n - 1; c++)
					grid[r][n-1] = grid[r][n-1] ^ grid[r][c];
			for (c = 0; c < n; c++)
				for (r = 0; r < n - 1; r++)
					grid[n-1][c] = grid[n-1][c] ^ grid[r][c];
			for (int k = 0; k < flips; k++) begin
				r = (k == 0 && fr >= 0) ? fr : $urandom_range(0, n - 1);
				c = (k == 0 && fc >= 0) ? fc : $urandom_range(0, n - 1);
				grid[r][c] = ~grid[r][c];
			end
		end
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				send_bit(grid[r][c]);
	endtask

	// report side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 250;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (!calm) begin
			result_stall <= ($urandom_range(0, 99) < 31);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		parity_report_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected report status=%0d row=%0d col=%0d",
					status, error_row, error_column));
			end else begin
				want = expected_reports.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (error_row !== want.row)
					report_mismatch($sformatf("error_row %0d, expected %0d",
						error_row, want.row));
				if (error_column !== want.col)
					report_mismatch($sformatf("error_column %0d, expected %0d",
						error_column, want.col));
				case (want.st)
					tdpc_pkg::ST_OK:      n_ok++;
					tdpc_pkg::ST_CORRUPT: n_corrupt++;
					default:              n_change++;
				endcase
			end
		end
	end

	// reset size of 4, single bad bit in row one, column one
	task automatic test_reset_size();
		send_matrix(4, 1, 0, 0);
	endtask

	task automatic test_small_sizes();
		write_size(7'd1);
		send_bit(1'b0);
		send_bit(1'b1);
		write_size(7'd0);
		send_bit(1'b1);
		write_size(7'd2);
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);
		// rewrite mid-matrix: the partial item count is dropped
		write_size(7'd2);
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b0);
	endtask

	// oversize and full-size writes with partial matrices, then a bad corner bit
	task automatic test_large_sizes();
		write_size(7'd127);
		repeat (64) send_bit(1'($urandom_range(0, 1)));
		write_size(7'd64);
		repeat (64) send_bit(1'($urandom_range(0, 1)));
		write_size(7'd12);
		send_matrix(12, 1, 11, 11);
	endtask

	task automatic test_backpressure();
		write_size(7'd1);
		hold_req = 1'b1;
		repeat (24) send_bit(1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_stream();
		int goal;
		int n;
		int pick;
		int stop;
		goal = items_sent + 560;
		while (items_sent < goal) begin
			calm = (items_sent > goal - 450) && (items_sent < goal - 250);
			if ($urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 6);
				write_size(n[tdpc_pkg::SizeW-1:0]);
			end
			n    = active_size();
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_matrix(n, $urandom_range(0, 3), -1, -1);
			end else if (pick < 85) begin
				send_matrix(n, -1, -1, -1);
			end else begin
				stop = $urandom_range(0, n * n - 1);
				repeat (stop) send_bit(1'($urandom_range(0, 1)));
				write_size(cur_size);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		size_valid   = 1'b0;
		matrix_size  = '0;
		bit_valid    = 1'b0;
		bit_value    = 1'b0;
		result_stall = 1'b0;
		errors       = 0;
		items_sent   = 0;
		n_ok         = 0;
		n_corrupt    = 0;
		n_change     = 0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		hold_left    = 0;
		cur_size     = tdpc_pkg::SizeW'(tdpc_pkg::ResetSize);
		clear_parity();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_small_sizes();
		test_large_sizes();
		test_backpressure();
		test_random_stream();

		drain();
		repeat (10) @(posedge clk);
		$display("Streamed %0d bits over sizes 0..127, incl. mid-matrix size writes", items_sent);
		$display("Reports checked: %0d ok, %0d corrupt, %0d single-bit; %0d mismatches",
			n_ok, n_corrupt, n_change, errors);
		if (errors == 0 && expected_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[two_dim_parity_checker.f]
src/tdpc_pkg.sv
src/tdpc_cell.sv
src/tdpc_ring.sv
src/two_dim_parity_checker.sv
tb/tb_top.sv
